### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the dot product block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

### design/cdp_pkg.sv
// ----------------------------------------------------------------------------
// cdp_pkg
// Types, constants and binary64 helper functions of the dot product block.
// ----------------------------------------------------------------------------
package cdp_pkg;

  localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [10:0] EXP_MAX   = 11'h7FF;

  // One product on its way from the multiplier to the accumulator.
  typedef struct packed {
    logic [63:0] prod;
    logic        last;
    logic        mode;
  } cdp_item_t;

  function automatic logic is_nan(input logic [63:0] v);
    return (v[62:52] == EXP_MAX) && (v[51:0] != 52'd0);
  endfunction

  function automatic logic is_inf(input logic [63:0] v);
    return (v[62:52] == EXP_MAX) && (v[51:0] == 52'd0);
  endfunction

  function automatic logic is_zero(input logic [63:0] v);
    return v[62:0] == 63'd0;
  endfunction

  function automatic logic [63:0] canon_nan(input logic [63:0] v);
    return is_nan(v) ? CANON_NAN : v;
  endfunction

  // Leading zero count; 128 when the word is zero.
  function automatic logic [7:0] lzc128(input logic [127:0] v);
    logic [7:0] n;
    n = 8'd128;
    for (int i = 0; i < 128; i++) begin
      if (v[i]) n = 8'(127 - i);
    end
    return n;
  endfunction

  // Right shift that folds every bit shifted out into the sticky bit 0.
  function automatic logic [55:0] shr_sticky(input logic [55:0] sig, input logic [6:0] sh);
    logic [55:0] r;
    logic [55:0] mask;
    logic        st;
    if (sh >= 7'd56) begin
      r  = 56'd0;
      st = |sig;
    end else begin
      r    = sig >> sh;
      mask = ~({56{1'b1}} << sh);
      st   = |(sig & mask);
    end
    return {r[55:1], r[0] | st};
  endfunction

  // Round to nearest even and pack. sig[55] is the hidden bit, sig[2] the guard
  // bit and sig[1:0] the sticky part. A clear hidden bit means a subnormal; the
  // rounding carry runs into the exponent field on its own.
  function automatic logic [63:0] fp_pack(input logic sign, input logic [11:0] e,
                                          input logic [55:0] sig);
    logic [62:0] w;
    logic        inc;
    logic [10:0] ef;
    if (e >= 12'd2047) return {sign, EXP_MAX, 52'd0};
    inc = sig[2] & (sig[3] | sig[1] | sig[0]);
    ef  = sig[55] ? e[10:0] : 11'd0;
    w   = {ef, sig[54:3]} + 63'(inc);
    return {sign, w};
  endfunction

endpackage

### design/cdp_front.sv
// ----------------------------------------------------------------------------
// cdp_front
// Accepts element pairs and multiplies them in a seven stage binary64 pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdp_front import cdp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] x_bits_i,
  input  logic [63:0] y_bits_i,
  input  logic        last_element_i,
  input  logic        mode_i,
  input  logic        pop_i,
  output logic        push_o,
  output cdp_item_t   item_o
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic               last;
    logic               mode;
    logic signed [13:0] esum;
  } meta_t;

  logic          accept;
  logic [CW-1:0] credit_q;
  logic [6:0]    vld_q;
  meta_t         m_d;
  meta_t         m_q [7];

  logic [10:0]         ex_adj, ey_adj;
  logic [52:0]         ma_q, mb_q;
  logic [53:0]         pp00_q;
  logic [52:0]         pp01_q, pp10_q;
  logic [51:0]         pp11_q;
  logic [53:0]         mid;
  logic [105:0]        p_q, p4_q;
  logic [6:0]          lz_q;
  logic [105:0]        norm;
  logic signed [13:0]  e5_q;
  logic [55:0]         sig5_q;
  logic signed [13:0]  sh14;
  logic [6:0]          sh7;
  logic [11:0]         e6_q;
  logic [55:0]         sig6_q;
  logic [63:0]         prod_q;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = credit_q < CW'(DEPTH);

  // Credits cover the queue and every product still in the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
      vld_q    <= '0;
    end else begin
      vld_q <= {vld_q[5:0], accept};
      if (accept && !pop_i) begin
        credit_q <= credit_q + CW'(1);
      end else if (!accept && pop_i) begin
        credit_q <= credit_q - CW'(1);
      end
    end
  end

  always_comb begin
    ex_adj    = (x_bits_i[62:52] == 11'd0) ? 11'd1 : x_bits_i[62:52];
    ey_adj    = (y_bits_i[62:52] == 11'd0) ? 11'd1 : y_bits_i[62:52];
    m_d.sign  = x_bits_i[63] ^ y_bits_i[63];
    m_d.nan   = is_nan(x_bits_i) || is_nan(y_bits_i) ||
                (is_inf(x_bits_i) && is_zero(y_bits_i)) ||
                (is_zero(x_bits_i) && is_inf(y_bits_i));
    m_d.inf   = is_inf(x_bits_i) || is_inf(y_bits_i);
    m_d.zero  = is_zero(x_bits_i) || is_zero(y_bits_i);
    m_d.last  = last_element_i;
    m_d.mode  = mode_i;
    m_d.esum  = $signed({3'b000, ex_adj}) + $signed({3'b000, ey_adj}) - 14'sd1023;
  end

  assign mid  = {1'b0, pp01_q} + {1'b0, pp10_q};
  assign norm = p4_q << lz_q;
  assign sh14 = 14'sd1 - e5_q;
  assign sh7  = (sh14 > 14'sd127) ? 7'd127 : sh14[6:0];

  always_ff @(posedge clk_i) begin
    m_q[0] <= m_d;
    for (int i = 1; i < 7; i++) m_q[i] <= m_q[i-1];
    // Stage 1: significands with hidden bits.
    ma_q <= {x_bits_i[62:52] != 11'd0, x_bits_i[51:0]};
    mb_q <= {y_bits_i[62:52] != 11'd0, y_bits_i[51:0]};
    // Stage 2: four partial products.
    pp00_q <= ma_q[26:0]  * mb_q[26:0];
    pp01_q <= ma_q[26:0]  * mb_q[52:27];
    pp10_q <= ma_q[52:27] * mb_q[26:0];
    pp11_q <= ma_q[52:27] * mb_q[52:27];
    // Stage 3: full product.
    p_q <= {pp11_q, 54'd0} + {25'd0, mid, 27'd0} + {52'd0, pp00_q};
    // Stage 4: leading zero count.
    p4_q <= p_q;
    lz_q <= 7'(lzc128({p_q, 22'd0}));
    // Stage 5: normalize.
    e5_q   <= m_q[3].esum + 14'sd1 - $signed({7'd0, lz_q});
    sig5_q <= {norm[105:51], |norm[50:0]};
    // Stage 6: denormalize results below the normal range.
    if (e5_q < 14'sd1) begin
      e6_q   <= 12'd1;
      sig6_q <= shr_sticky(sig5_q, sh7);
    end else begin
      e6_q   <= e5_q[11:0];
      sig6_q <= sig5_q;
    end
    // Stage 7: round and pack, special values override.
    if (m_q[5].nan) begin
      prod_q <= CANON_NAN;
    end else if (m_q[5].inf) begin
      prod_q <= {m_q[5].sign, EXP_MAX, 52'd0};
    end else if (m_q[5].zero) begin
      prod_q <= {m_q[5].sign, 63'd0};
    end else begin
      prod_q <= fp_pack(m_q[5].sign, e6_q, sig6_q);
    end
  end

  assign push_o      = vld_q[6];
  assign item_o.prod = prod_q;
  assign item_o.last = m_q[6].last;
  assign item_o.mode = m_q[6].mode;

  `ASSERT_ALWAYS(a_credit_bound, clk_i, rst_ni, credit_q <= CW'(DEPTH), "credit overrun")

endmodule

### design/cdp_fifo.sv
// ----------------------------------------------------------------------------
// cdp_fifo
// Short queue of products between the multiplier and the accumulator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdp_fifo import cdp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cdp_item_t item_i,
  input  logic      pop_i,
  output logic      valid_o,
  output cdp_item_t item_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cdp_item_t     mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  assign valid_o = count_q != '0;
  assign item_o  = mem_q[rd_ptr_q];

  `ASSERT_ALWAYS(a_no_overflow, clk_i, rst_ni, !(push_i && count_q == CW'(DEPTH)), "push into full queue")
  `ASSERT_ALWAYS(a_no_underflow, clk_i, rst_ni, !(pop_i && count_q == '0), "pop from empty queue")

endmodule

### design/cdp_fadd.sv
// ----------------------------------------------------------------------------
// cdp_fadd
// Five stage binary64 adder and subtractor, round to nearest even.
// ----------------------------------------------------------------------------
module cdp_fadd import cdp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic        sub_i,
  output logic        done_o,
  output logic [63:0] sum_o
);

  typedef struct packed {
    logic sign;
    logic eff_sub;
    logic nan;
    logic inf;
    logic zsign;
  } flags_t;

  logic [4:0]  vld_q;
  logic [63:0] bb, big, sml;
  logic        a_ge;
  logic [10:0] eb, es, d;
  flags_t      f_d;
  flags_t      f_q [4];

  logic [55:0] big1_q, sml1_q, al;
  logic [6:0]  d1_q;
  logic [10:0] eb_q [3];
  logic [56:0] s2_q, s3_q;
  logic [5:0]  lz3_q, sh;
  logic [11:0] e4_q;
  logic [55:0] sig4_q;
  logic        z4_q;
  logic [63:0] res_q;

  always_comb begin
    bb        = {b_i[63] ^ sub_i, b_i[62:0]};
    a_ge      = a_i[62:0] >= bb[62:0];
    big       = a_ge ? a_i : bb;
    sml       = a_ge ? bb : a_i;
    eb        = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    es        = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
    d         = eb - es;
    f_d.sign    = big[63];
    f_d.eff_sub = a_i[63] ^ bb[63];
    f_d.nan     = is_nan(a_i) || is_nan(bb) || (is_inf(a_i) && is_inf(bb) && f_d.eff_sub);
    f_d.inf     = is_inf(a_i) || is_inf(bb);
    // An exact zero from cancellation is +0; like signed zeros keep their sign.
    f_d.zsign   = f_d.eff_sub ? 1'b0 : big[63];
  end

  assign al = shr_sticky(sml1_q, d1_q);
  // Only taken when the leading one lies at or past the minimum exponent.
  assign sh = ({6'd0, lz3_q} < {1'b0, eb_q[2]}) ? lz3_q : 6'(eb_q[2] - 11'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // Stage 1: order by magnitude.
    f_q[0]  <= f_d;
    big1_q  <= {big[62:52] != 11'd0, big[51:0], 3'b000};
    sml1_q  <= {sml[62:52] != 11'd0, sml[51:0], 3'b000};
    d1_q    <= (d > 11'd127) ? 7'd127 : d[6:0];
    eb_q[0] <= eb;
    // Stage 2: align and add.
    f_q[1]  <= f_q[0];
    eb_q[1] <= eb_q[0];
    s2_q    <= f_q[0].eff_sub ? {1'b0, big1_q} - {1'b0, al} : {1'b0, big1_q} + {1'b0, al};
    // Stage 3: leading zeros.
    f_q[2]  <= f_q[1];
    eb_q[2] <= eb_q[1];
    s3_q    <= s2_q;
    lz3_q   <= 6'(lzc128({s2_q[55:0], 72'd0}));
    // Stage 4: normalize.
    f_q[3]  <= f_q[2];
    z4_q    <= s3_q == 57'd0;
    if (s3_q[56]) begin
      sig4_q <= {s3_q[56:2], s3_q[1] | s3_q[0]};
      e4_q   <= {1'b0, eb_q[2]} + 12'd1;
    end else begin
      sig4_q <= s3_q[55:0] << sh;
      e4_q   <= {1'b0, eb_q[2]} - {6'd0, sh};
    end
    // Stage 5: round and pack.
    if (f_q[3].nan) begin
      res_q <= CANON_NAN;
    end else if (f_q[3].inf) begin
      res_q <= {f_q[3].sign, EXP_MAX, 52'd0};
    end else if (z4_q) begin
      res_q <= {f_q[3].zsign, 63'd0};
    end else begin
      res_q <= fp_pack(f_q[3].sign, e4_q, sig4_q);
    end
  end

  assign done_o = vld_q[4];
  assign sum_o  = res_q;

endmodule

### design/cdp_back.sv
// ----------------------------------------------------------------------------
// cdp_back
// Accumulator sequencer: runs the compensated or plain sum on the shared adder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdp_back import cdp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  cdp_item_t   item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] dot_sum_bits_o
);

  typedef enum logic [2:0] {ST_IDLE, ST_Q, ST_T, ST_U, ST_V, ST_END} state_e;

  state_e      state_q;
  logic        launch_q;
  logic        last_q, mode_q;
  logic [63:0] s_q, c_q, q_q, t_q, u_q;
  logic        out_valid_q;
  logic [63:0] out_data_q;
  logic [63:0] op_a, op_b;
  logic        op_sub;
  logic        sum_valid;
  logic [63:0] sum;
  logic        out_free;

  always_comb begin
    unique case (state_q)
      ST_Q:    begin op_a = q_q; op_b = c_q; op_sub = 1'b1; end
      ST_T:    begin op_a = s_q; op_b = q_q; op_sub = 1'b0; end
      ST_U:    begin op_a = t_q; op_b = s_q; op_sub = 1'b1; end
      ST_V:    begin op_a = u_q; op_b = q_q; op_sub = 1'b1; end
      default: begin op_a = s_q; op_b = q_q; op_sub = 1'b0; end
    endcase
  end

  cdp_fadd u_fadd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (launch_q),
    .a_i     (op_a),
    .b_i     (op_b),
    .sub_i   (op_sub),
    .done_o  (sum_valid),
    .sum_o   (sum)
  );

  assign pop_o    = (state_q == ST_IDLE) && item_valid_i;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launch_q    <= 1'b0;
      last_q      <= 1'b0;
      mode_q      <= 1'b0;
      s_q         <= '0;
      c_q         <= '0;
      q_q         <= '0;
      t_q         <= '0;
      u_q         <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      launch_q <= 1'b0;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            q_q      <= item_i.prod;
            last_q   <= item_i.last;
            mode_q   <= item_i.mode;
            state_q  <= item_i.mode ? ST_Q : ST_T;
            launch_q <= 1'b1;
          end
        end
        ST_Q: begin
          if (sum_valid) begin
            q_q      <= sum;
            state_q  <= ST_T;
            launch_q <= 1'b1;
          end
        end
        ST_T: begin
          if (sum_valid) begin
            t_q <= sum;
            if (mode_q) begin
              state_q  <= ST_U;
              launch_q <= 1'b1;
            end else begin
              state_q <= ST_END;
            end
          end
        end
        ST_U: begin
          if (sum_valid) begin
            u_q      <= sum;
            state_q  <= ST_V;
            launch_q <= 1'b1;
          end
        end
        ST_V: begin
          if (sum_valid) begin
            c_q     <= sum;
            state_q <= ST_END;
          end
        end
        ST_END: begin
          if (!last_q) begin
            s_q     <= t_q;
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= canon_nan(t_q);
            s_q         <= '0;
            c_q         <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dot_sum_bits_o = out_data_q;

  `ASSERT_ALWAYS(a_sum_when_busy, clk_i, rst_ni, !(sum_valid && (state_q == ST_IDLE || state_q == ST_END)), "adder result with no operation pending")

endmodule

### design/compensated_dot_product.sv
// The accumulator takes one item at a time and finishes it before the next: four
//   dependent adds on the shared adder with compensation on, one with it off, plus fetch and retire.
// An item passes the multiplier pipeline and the queue before the accumulator takes it;
//   a last item's sum enters the output register once its adds finish and that register is free.
// Reset: asynchronous, active low; clears sum and error to +0 and compensation to on.
// ----------------------------------------------------------------------------
// compensated_dot_product
// Streams binary64 element pairs and accumulates their dot product, with
// optional Kahan compensation of the running sum.
// ----------------------------------------------------------------------------
module compensated_dot_product import cdp_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] x_bits_i,
  input  logic [63:0] y_bits_i,
  input  logic        last_element_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] dot_sum_bits_o
);

  // The front multiplies each item in a seven stage pipeline and keeps
  // credits so that every product it starts has a queue slot waiting. The
  // back runs the additions on one shared adder and holds a finished sum in
  // its output register while it already works on the next vector.

  logic      comp_en_q;
  logic      push;
  logic      pop;
  logic      fifo_valid;
  cdp_item_t front_item;
  cdp_item_t fifo_item;

  // The compensation mode travels with each item, so a change only affects
  // items accepted after the write.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_en_q <= 1'b1;
    end else if (cfg_valid_i) begin
      comp_en_q <= cfg_data_i;
    end
  end

  cdp_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .x_bits_i       (x_bits_i),
    .y_bits_i       (y_bits_i),
    .last_element_i (last_element_i),
    .mode_i         (comp_en_q),
    .pop_i          (pop),
    .push_o         (push),
    .item_o         (front_item)
  );

  cdp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .item_o  (fifo_item)
  );

  // Each compensated step computes q = p - c, t = s + q, c = (t - s) - q and
  // s = t, every operation rounded on its own. The last item of a vector
  // delivers s, with any NaN made canonical, and clears s and c to +0.
  cdp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (fifo_valid),
    .item_i         (fifo_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dot_sum_bits_o (dot_sum_bits_o)
  );

endmodule

### test/tb_compensated_dot_product.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_compensated_dot_product
// Streams binary64 element pairs into the dot product block and checks every
// emitted sum bit for bit against a prediction built on native real arithmetic.
// ----------------------------------------------------------------------------
module tb_compensated_dot_product;

  typedef struct {
    logic [63:0] x;
    logic [63:0] y;
    logic        last;
  } pair_t;

  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam int          IDLE_PCT  = 29;
  localparam int          SETTLE    = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] x_bits_i = '0;
  logic [63:0] y_bits_i = '0;
  logic        last_element_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] dot_sum_bits_o;

  // Stimulus waiting for the driver and sums waiting for the block.
  pair_t       pending_pairs[$];
  logic [63:0] expected_sums[$];

  // Shadow of the accumulator state and of the mode register.
  logic [63:0] acc_sum = '0;
  logic [63:0] acc_err = '0;
  logic        kahan_on = 1'b1;

  int errors = 0;
  bit calm = 1'b0;          // When set, neither side idles.
  int hold_req = 0;         // Bumped to ask the receiver for a long hold-off.
  int hold_seen = 0;
  int hold_left = 0;

  compensated_dot_product i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .x_bits_i       (x_bits_i),
    .y_bits_i       (y_bits_i),
    .last_element_i (last_element_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dot_sum_bits_o (dot_sum_bits_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Any NaN leaves the block in its one canonical quiet form.
  function automatic logic [63:0] quiet_nan(input logic [63:0] v);
    if (v[62:52] == 11'h7FF && v[51:0] != 52'd0) return QNAN_BITS;
    return v;
  endfunction

  // Advance the accumulator by one pair. Every real operation is a separately
  // rounded binary64 operation, which matches the block's arithmetic.
  task automatic accumulate(input pair_t p);
    real prod, corr, t, u, s, c;
    s    = $bitstoreal(acc_sum);
    c    = $bitstoreal(acc_err);
    prod = $bitstoreal(p.x) * $bitstoreal(p.y);
    if (kahan_on) begin
      corr    = prod - c;
      t       = s + corr;
      u       = t - s;
      u       = u - corr;
      acc_sum = $realtobits(t);
      acc_err = $realtobits(u);
    end else begin
      t       = s + prod;
      acc_sum = $realtobits(t);
    end
    if (p.last) begin
      expected_sums.push_back(quiet_nan(acc_sum));
      acc_sum = '0;
      acc_err = '0;
    end
  endtask

  // Driver: takes the next pair once the previous one is accepted, and the
  // prediction is advanced at the very edge where a pair is accepted.
  always @(posedge clk_i) begin
    pair_t p;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        p.x = x_bits_i;
        p.y = y_bits_i;
        p.last = last_element_i;
        accumulate(p);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_pairs.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          p = pending_pairs.pop_front();
          in_valid_i     <= 1'b1;
          x_bits_i       <= p.x;
          y_bits_i       <= p.y;
          last_element_i <= p.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted sum and drives the receiver's ready.
  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected sum, expected none, actual %h", $time, dot_sum_bits_o);
          errors++;
        end else begin
          want = expected_sums.pop_front();
          if (want !== dot_sum_bits_o) begin
            $display("%0t: dot_sum_bits mismatch, expected %h, actual %h",
                     $time, want, dot_sum_bits_o);
            errors++;
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen   <= hold_req;
        hold_left   <= 600;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  task automatic push_pair(input logic [63:0] x, input logic [63:0] y, input logic last);
    pair_t p;
    p.x = x;
    p.y = y;
    p.last = last;
    pending_pairs.push_back(p);
  endtask

  // Finite value of moderate size, so that long vectors stay meaningful.
  function automatic logic [63:0] tame_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    v[62:52] = 11'(1023 - 40 + $urandom_range(80));
    return v;
  endfunction

  // Anything at all: raw patterns, specials, subnormals and zeros.
  function automatic logic [63:0] wild_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v[62:52] = 11'h7FF;
      1: v[62:52] = 11'h000;
      2: v[62:0]  = '0;
      default: ;
    endcase
    return v;
  endfunction

  // Mostly well-formed vectors of finite values, some of raw noise.
  task automatic push_random_vectors(input int n_pairs);
    int  len;
    bit  noisy;
    while (n_pairs > 0) begin
      len   = $urandom_range(1, 8);
      noisy = $urandom_range(99) < 15;
      for (int k = 0; k < len; k++) begin
        if (noisy) push_pair(wild_value(), wild_value(), k == len - 1);
        else       push_pair(tame_value(), tame_value(), k == len - 1);
      end
      n_pairs -= len;
    end
  endtask

  // Wait until the stream has drained, then give in-flight pairs that carry
  // no last mark time to reach the accumulator.
  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid_i || expected_sums.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    kahan_on     = v;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: signed zeros, infinities, NaNs, overflow, subnormals and
    // a cancellation of two large products around a small term.
    push_pair(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1);
    push_pair(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000, 1'b1);
    push_pair(64'h7FF0_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b1);
    push_pair(64'h7FF0_0000_0000_0000, 64'h0000_0000_0000_0000, 1'b1);
    push_pair(64'hFFF4_0000_0000_0001, 64'h3FF0_0000_0000_0000, 1'b1);
    push_pair(64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 1'b1);
    push_pair(64'h0000_0000_0000_0001, 64'h3FF0_0000_0000_0000, 1'b1);
    push_pair(64'h000F_FFFF_FFFF_FFFF, 64'h3FE0_0000_0000_0000, 1'b1);
    push_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    push_pair(64'h4197_D784_0000_0000, 64'h4197_D784_0000_0000, 1'b0);
    push_pair(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b0);
    push_pair(64'hC197_D784_0000_0000, 64'h4197_D784_0000_0000, 1'b1);
    push_pair(64'h7FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b0);
    push_pair(64'hFFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1);
    drain();

    // Plain accumulation, with the same cancellation and a vector left open
    // across the switch back, so the mode changes inside a vector.
    set_mode(1'b0);
    push_pair(64'h4197_D784_0000_0000, 64'h4197_D784_0000_0000, 1'b0);
    push_pair(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b0);
    push_pair(64'hC197_D784_0000_0000, 64'h4197_D784_0000_0000, 1'b1);
    push_random_vectors(300);
    push_pair(tame_value(), tame_value(), 1'b0);
    drain();

    // Compensated again; the receiver stalls for a long stretch so the block
    // fills and holds off its input.
    set_mode(1'b1);
    push_random_vectors(150);
    hold_req++;
    push_random_vectors(150);
    drain();

    // Neither side idles here.
    set_mode(1'b0);
    calm = 1'b1;
    push_random_vectors(200);
    drain();
    calm = 1'b0;

    set_mode(1'b1);
    push_random_vectors(230);
    push_pair(64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1);
    drain();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/cdp_pkg.sv
design/cdp_front.sv
design/cdp_fifo.sv
design/cdp_fadd.sv
design/cdp_back.sv
design/compensated_dot_product.sv
test/tb_compensated_dot_product.sv
